@@ rtl/core/uglr_pkg.sv @@
// ----------------------------------------------------------------------------
// uglr_pkg
// Shared widths, limits and controller/datapath interface types for the
// uniform grid linear resampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package uglr_pkg;

    localparam int TIME_W    = 32;
    localparam int VALUE_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int MAX_RUN   = 64;
    localparam int CFG_W     = 32;

    // stream payload: time in the low bits, value above it
    localparam int DATA_W = TIME_W + VALUE_W;

    localparam int RUN_CNT_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    // divider: dividend holds dt * |dv| + span/2, divisor holds a time span
    localparam int DIVIDEND_W = TIME_W + VALUE_W;
    localparam int DIV_RADIX  = 2;
    localparam int DIV_CYCLES = DIVIDEND_W / DIV_RADIX;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    // grid step of 1.0
    localparam logic [TIME_W-1:0] STEP_RESET = TIME_W'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic capture;
        logic decide;
        logic set_origin;
        logic set_prev_value;
        logic commit;
        logic mul_n;
        logic mul_a;
        logic div_start;
        logic load_run;
        logic emit_point;
        logic emit_start;
        logic skip_start;
        logic skip_fix;
    } uglr_cmd_t;

    typedef struct packed {
        logic new_series;
        logic time_lt;
        logic time_eq;
        logic has_points;
        logic div_done;
        logic div_pair_done;
        logic out_free;
        logic run_last;
        logic run_trunc;
    } uglr_status_t;

endpackage

`default_nettype wire

@@ rtl/core/uglr_div.sv @@
// ----------------------------------------------------------------------------
// uglr_div
// Restoring unsigned divider, DIV_RADIX quotient bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uglr_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [uglr_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [uglr_pkg::TIME_W-1:0]        divisor,
    output logic                               done,
    output logic [uglr_pkg::VALUE_W-1:0]       quotient,
    output logic [uglr_pkg::TIME_W-1:0]        remainder
);
    import uglr_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] work_reg, work_next;
    logic [TIME_W-1:0]     rem_reg, rem_next;
    logic [TIME_W-1:0]     divisor_reg;
    logic [TIME_W:0]       trial;

    // work register shifts the dividend out and the quotient in
    always_comb begin
        work_next = work_reg;
        rem_next  = rem_reg;
        trial     = '0;
        for (int i = 0; i < DIV_RADIX; i++) begin
            trial     = {rem_next, work_next[DIVIDEND_W-1]};
            work_next = {work_next[DIVIDEND_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg}) begin
                trial        = trial - {1'b0, divisor_reg};
                work_next[0] = 1'b1;
            end
            rem_next = trial[TIME_W-1:0];
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = work_reg[VALUE_W-1:0];
    assign remainder = rem_reg;

endmodule

`default_nettype wire

@@ rtl/core/uglr_datapath.sv @@
// ----------------------------------------------------------------------------
// uglr_datapath
// Series state, slope setup (shared multiplier, two dividers), incremental
// interpolation of grid points and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uglr_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  uglr_pkg::uglr_cmd_t            cmd,
    output uglr_pkg::uglr_status_t         status,
    input  logic [uglr_pkg::DATA_W-1:0]    s_tdata,
    input  logic                           s_tuser,
    input  logic                           cfg_wr_en,
    input  logic [uglr_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [uglr_pkg::DATA_W-1:0]    m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);
    import uglr_pkg::*;

    // series state
    logic [TIME_W-1:0]  step_reg;
    logic               have_origin_reg;
    logic [TIME_W-1:0]  prev_time_reg;
    logic [VALUE_W-1:0] prev_value_reg;
    logic [TIME_W:0]    ngt_reg, ngt_next;

    // captured request
    logic [TIME_W-1:0]  in_time_reg;
    logic [VALUE_W-1:0] in_value_reg;
    logic               in_start_reg;

    // run setup
    logic [TIME_W-1:0]     span_reg;
    logic [VALUE_W:0]      mag_reg;
    logic                  neg_reg;
    logic [TIME_W-1:0]     dt0_reg;
    logic [DIVIDEND_W-1:0] prod_reg;
    logic [DIVIDEND_W-1:0] n0_reg;

    // running quotient/remainder of the interpolation
    logic [VALUE_W-1:0]   q_reg, qa_reg;
    logic [TIME_W-1:0]    r_reg, ra_reg;
    logic [RUN_CNT_W-1:0] cnt_reg;

    // output register
    logic               m_valid_reg;
    logic [TIME_W-1:0]  m_time_reg;
    logic [VALUE_W-1:0] m_value_reg;
    logic               m_last_reg;
    logic               m_trunc_reg;

    logic [TIME_W-1:0]       step_eff;
    logic [VALUE_W:0]        dv;
    logic [VALUE_W:0]        mag;
    logic [TIME_W-1:0]       mul_op;
    logic [DIVIDEND_W:0]     mul_full;
    logic [TIME_W:0]         t_ext;
    logic [TIME_W:0]         ngt_step;
    logic                    run_full;
    logic                    past_t;
    logic [TIME_W:0]         r_sum;
    logic                    wrap;
    logic [TIME_W-1:0]       r_next;
    logic [VALUE_W-1:0]      q_next;
    logic [VALUE_W-1:0]      point_value;
    logic [TIME_W:0]         ngt_fix;

    logic                    div_a_start;
    logic [DIVIDEND_W-1:0]   div_a_dividend;
    logic [TIME_W-1:0]       div_a_divisor;
    logic                    div_a_done, div_b_done;
    logic [VALUE_W-1:0]      div_a_quot, div_b_quot;
    logic [TIME_W-1:0]       div_a_rem, div_b_rem;

    assign step_eff = (step_reg == '0) ? TIME_W'(1) : step_reg;
    assign t_ext    = {1'b0, in_time_reg};

    assign dv  = {in_value_reg[VALUE_W-1], in_value_reg}
               - {prev_value_reg[VALUE_W-1], prev_value_reg};
    assign mag = dv[VALUE_W] ? ((VALUE_W+1)'(0) - dv) : dv;

    assign mul_op   = cmd.mul_a ? step_eff : dt0_reg;
    assign mul_full = (DIVIDEND_W+1)'(mul_op) * (DIVIDEND_W+1)'(mag_reg);

    assign ngt_step = ngt_reg + {1'b0, step_eff};
    assign run_full = (cnt_reg == RUN_CNT_W'(MAX_RUN - 1));
    assign past_t   = (ngt_step > t_ext);

    // next point: add the per-step quotient and carry out of the remainder
    assign r_sum  = {1'b0, r_reg} + {1'b0, ra_reg};
    assign wrap   = (r_sum >= {1'b0, span_reg});
    assign r_next = wrap ? TIME_W'(r_sum - {1'b0, span_reg}) : r_sum[TIME_W-1:0];
    assign q_next = q_reg + qa_reg + VALUE_W'(wrap);

    assign point_value = neg_reg ? (prev_value_reg - q_reg) : (prev_value_reg + q_reg);

    // first grid point past the sample: t - ((t - ngt) mod step) + step
    assign ngt_fix = t_ext - {1'b0, div_a_rem} + {1'b0, step_eff};

    assign div_a_start    = cmd.div_start | cmd.skip_start;
    assign div_a_dividend = cmd.skip_start
                          ? DIVIDEND_W'(in_time_reg - ngt_reg[TIME_W-1:0]) : n0_reg;
    assign div_a_divisor  = cmd.skip_start ? step_eff : span_reg;

    uglr_div u_div_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_a_start),
        .dividend  (div_a_dividend),
        .divisor   (div_a_divisor),
        .done      (div_a_done),
        .quotient  (div_a_quot),
        .remainder (div_a_rem)
    );

    uglr_div u_div_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (prod_reg),
        .divisor   (span_reg),
        .done      (div_b_done),
        .quotient  (div_b_quot),
        .remainder (div_b_rem)
    );

    always_comb begin
        status.new_series    = in_start_reg | ~have_origin_reg;
        status.time_lt       = (in_time_reg < prev_time_reg);
        status.time_eq       = (in_time_reg == prev_time_reg);
        status.has_points    = (ngt_reg <= t_ext);
        status.div_done      = div_a_done;
        status.div_pair_done = div_a_done & div_b_done;
        status.out_free      = ~m_valid_reg | m_tready;
        status.run_last      = run_full | past_t;
        status.run_trunc     = run_full & ~past_t;
    end

    always_comb begin
        ngt_next = ngt_reg;
        if (cmd.set_origin) begin
            ngt_next = t_ext + {1'b0, step_eff};
        end else if (cmd.emit_point) begin
            ngt_next = ngt_step;
        end else if (cmd.skip_fix) begin
            ngt_next = ngt_fix;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg        <= STEP_RESET;
            have_origin_reg <= 1'b0;
            prev_time_reg   <= '0;
            prev_value_reg  <= '0;
            ngt_reg         <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                step_reg <= cfg_wr_data[TIME_W-1:0];
            end
            if (cmd.set_origin) begin
                have_origin_reg <= 1'b1;
            end
            if (cmd.set_origin || cmd.commit) begin
                prev_time_reg  <= in_time_reg;
                prev_value_reg <= in_value_reg;
            end else if (cmd.set_prev_value) begin
                prev_value_reg <= in_value_reg;
            end
            ngt_reg <= ngt_next;
            if (cmd.emit_point || cmd.emit_start) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_time_reg  <= s_tdata[TIME_W-1:0];
            in_value_reg <= s_tdata[DATA_W-1:TIME_W];
            in_start_reg <= s_tuser;
        end
        if (cmd.decide) begin
            span_reg <= in_time_reg - prev_time_reg;
            mag_reg  <= mag;
            neg_reg  <= dv[VALUE_W];
            dt0_reg  <= ngt_reg[TIME_W-1:0] - prev_time_reg;
        end
        if (cmd.mul_n || cmd.mul_a) begin
            prod_reg <= mul_full[DIVIDEND_W-1:0];
        end
        if (cmd.mul_a) begin
            // rounding offset: half the span
            n0_reg <= prod_reg + DIVIDEND_W'(span_reg >> 1);
        end
        if (cmd.load_run) begin
            q_reg   <= div_a_quot;
            r_reg   <= div_a_rem;
            qa_reg  <= div_b_quot;
            ra_reg  <= div_b_rem;
            cnt_reg <= '0;
        end else if (cmd.emit_point) begin
            q_reg   <= q_next;
            r_reg   <= r_next;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.emit_point) begin
            m_time_reg  <= ngt_reg[TIME_W-1:0];
            m_value_reg <= point_value;
            m_last_reg  <= status.run_last;
            m_trunc_reg <= status.run_trunc;
        end else if (cmd.emit_start) begin
            m_time_reg  <= in_time_reg;
            m_value_reg <= in_value_reg;
            m_last_reg  <= 1'b1;
            m_trunc_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_value_reg, m_time_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_trunc_reg;

endmodule

`default_nettype wire

@@ rtl/core/uglr_ctrl.sv @@
// ----------------------------------------------------------------------------
// uglr_ctrl
// Per-sample sequencer: classify, emit series starts, set up the slope, run
// the dividers, emit grid points and realign the grid after a cut-short run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uglr_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  uglr_pkg::uglr_status_t  status,
    output uglr_pkg::uglr_cmd_t     cmd
);
    import uglr_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_DECIDE    = 10'b00_0000_0010,
        ST_MUL_N     = 10'b00_0000_0100,
        ST_MUL_A     = 10'b00_0000_1000,
        ST_DIV_LOAD  = 10'b00_0001_0000,
        ST_DIV_WAIT  = 10'b00_0010_0000,
        ST_EMIT      = 10'b00_0100_0000,
        ST_SKIP_LOAD = 10'b00_1000_0000,
        ST_SKIP_WAIT = 10'b01_0000_0000,
        ST_START_OUT = 10'b10_0000_0000
    } uglr_state_t;

    uglr_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                if (status.new_series) begin
                    cmd.set_origin = 1'b1;
                    state_next     = ST_START_OUT;
                end else if (status.time_lt) begin
                    state_next = ST_IDLE;
                end else if (status.time_eq) begin
                    cmd.set_prev_value = 1'b1;
                    state_next         = ST_IDLE;
                end else if (!status.has_points) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_MUL_N;
                end
            end
            ST_MUL_N: begin
                cmd.mul_n  = 1'b1;
                state_next = ST_MUL_A;
            end
            ST_MUL_A: begin
                cmd.mul_a  = 1'b1;
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (status.div_pair_done) begin
                    cmd.load_run = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit_point = 1'b1;
                    if (status.run_last) begin
                        if (status.run_trunc) begin
                            state_next = ST_SKIP_LOAD;
                        end else begin
                            cmd.commit = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_SKIP_LOAD: begin
                cmd.skip_start = 1'b1;
                state_next     = ST_SKIP_WAIT;
            end
            ST_SKIP_WAIT: begin
                if (status.div_done) begin
                    cmd.skip_fix = 1'b1;
                    cmd.commit   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_START_OUT: begin
                if (status.out_free) begin
                    cmd.emit_start = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/uniform_grid_linear_resampler.sv @@
// ----------------------------------------------------------------------------
// uniform_grid_linear_resampler
// Resamples one series of (time, value) samples onto the grid origin+j*step
// by linear interpolation with round-to-nearest.
// ----------------------------------------------------------------------------
// flow: a series-start sample goes through START_OUT to the output register
// a sample that produces grid points runs a setup (two 64-bit divisions on
// 2-bit-per-cycle dividers), then emits one point a cycle while output is free
// a run cut short at MAX_RUN adds a further division for the grid realignment
// a sample with no points or an out-of-order time is retired in DECIDE
// reset: aresetn synchronous, active low; grid_step returns to 1.0, no origin
`timescale 1ns / 1ps
`default_nettype none

module uniform_grid_linear_resampler (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [uglr_pkg::CFG_W-1:0]      cfg_wr_data,  // grid_step
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [uglr_pkg::DATA_W-1:0]     s_tdata,      // sample_time, sample_value
    input  logic                            s_tuser,      // start_series
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [uglr_pkg::DATA_W-1:0]     m_tdata,      // grid_time, grid_value
    output logic                            m_tlast,      // last_of_run
    output logic                            m_tuser       // truncated
);
    import uglr_pkg::*;

    uglr_cmd_t    cmd;
    uglr_status_t status;

    uglr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    uglr_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

`ifndef NO_ASSERTIONS
    // a point is only loaded when the output register is free
    a_emit_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_point || cmd.emit_start) |-> status.out_free)
        else $error("point loaded over a pending result");

    // a cut-short run is flagged on its final point only
    a_trunc_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("truncated flag without last_of_run");

    // a captured sample keeps the input closed for the next cycle
    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input reopened right after a request");
`endif

endmodule

`default_nettype wire
